// File: rtl/core/twiddle_coordinate_tuner_unit_assert.svh
// ----------------------------------------------------------------------------
// Twiddle coordinate tuner assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWIDDLE_COORDINATE_TUNER_UNIT_ASSERT_SVH
`define TWIDDLE_COORDINATE_TUNER_UNIT_ASSERT_SVH

// consequent in the same cycle
`define TCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the next cycle
`define TCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/tct_pkg.sv
// ----------------------------------------------------------------------------
// Twiddle coordinate tuner package
// Widths, constants, codes and fixed-point helpers shared by the tuner.
// ----------------------------------------------------------------------------
`default_nettype none

package tct_pkg;

	localparam int unsigned DATA_W        = 32;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned NUM_GAINS_DEF = 3;
	localparam int unsigned NUM_GAIN_REGS = 3;
	localparam int unsigned IDX_OUT_W     = 2;

	// Q16.16 constants: 0.1, 1.1, 0.9
	localparam logic [16:0] K_TENTH  = 17'd6554;
	localparam logic [16:0] K_GROW   = 17'd72090;
	localparam logic [16:0] K_SHRINK = 17'd58982;

	localparam logic [DATA_W-1:0] BEST_RST = 32'hFFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_0,
		REG_GAIN_1,
		REG_GAIN_2,
		REG_BEST
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_ADD,
		ACT_SUB,
		ACT_SHRINK
	} action_t;

	typedef logic signed [DATA_W-1:0] gain_t;

	// saturate a 35-bit signed value to 32 bits
	function automatic gain_t sat35(input logic signed [34:0] v);
		gain_t r;
		if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
			r = v[31:0];
		end else if (v[34]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

	// x * c in Q16.16, floor, saturate
	function automatic gain_t mul_q16(input gain_t x, input logic [16:0] c);
		logic signed [49:0] xe;
		logic signed [49:0] ce;
		logic signed [49:0] p;
		logic signed [33:0] q;
		xe = 50'(x);
		ce = $signed(50'(c));
		p  = xe * ce;
		q  = p[49:16];
		return sat35(35'(q));
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/tct_trial_if.sv
// ----------------------------------------------------------------------------
// Trial error channel
// Valid/ready channel carrying the error word of one trial run.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_trial_if;

	logic        valid;
	logic        ready;
	logic [31:0] trial_error;

	modport source (output valid, output trial_error, input ready);
	modport sink   (input valid, input trial_error, output ready);

endinterface

`default_nettype wire

// File: rtl/core/tct_result_if.sv
// ----------------------------------------------------------------------------
// Tuner result channel
// Valid/ready channel carrying the gain vector and the step report.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_result_if;

	logic               valid;
	logic               ready;
	logic signed [31:0] gain_0;
	logic signed [31:0] gain_1;
	logic signed [31:0] gain_2;
	logic        [1:0]  tuned_index;
	logic               improved;
	logic        [1:0]  action;

	modport source (
		output valid, output gain_0, output gain_1, output gain_2,
		output tuned_index, output improved, output action, input ready
	);
	modport sink (
		input valid, input gain_0, input gain_1, input gain_2,
		input tuned_index, input improved, input action, output ready
	);

endinterface

`default_nettype wire

// File: rtl/core/twiddle_coordinate_tuner_unit.sv
// ----------------------------------------------------------------------------
// Twiddle coordinate tuner
// Coordinate-descent tuner of a gain vector, one trial error word per step.
//
// Channel   Dir   Payload
// trial     in    trial_error
// result    out   gain_0..2, tuned_index, improved, action
// cfg       in    cfg_we, cfg_index, cfg_data (write only)
//
// One word per cycle sustained while result.ready is high. A word is held in
// s1, then one pass (compare, constant multiply, saturating add) loads the
// result register and updates gain and step registers unless cfg_we is high.
// The result register parts the sides: a word is taken while a result waits
// if s1 is empty. Reset: pipeline clear, gains 0, steps 0, best error all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module twiddle_coordinate_tuner_unit #(
	parameter int unsigned NUM_GAINS = tct_pkg::NUM_GAINS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tct_pkg::DATA_W-1:0]     cfg_data,
	tct_trial_if.sink                           trial,
	tct_result_if.source                        result
);

	import tct_pkg::*;

	`include "twiddle_coordinate_tuner_unit_assert.svh"

	localparam int unsigned IDX_W = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;

	logic                v_s1;
	logic [DATA_W-1:0]   err_s1;
	logic                v_s2;
	gain_t               gout_s2 [NUM_GAIN_REGS];
	logic [IDX_OUT_W-1:0] tidx_s2;
	logic                imp_s2;
	action_t             act_s2;

	gain_t               gain_q [NUM_GAINS];
	gain_t               step_q [NUM_GAINS];
	logic [DATA_W-1:0]   best_q;
	logic [IDX_W-1:0]    cur_q;
	logic                step_add_q;
	logic                step_sub_q;

	gain_t               gain_n [NUM_GAINS];
	gain_t               step_n [NUM_GAINS];
	gain_t               gout   [NUM_GAIN_REGS];
	logic [IDX_W-1:0]    nxt;
	logic [IDX_W-1:0]    idx;
	logic [IDX_W-1:0]    cur_n;
	logic [IDX_W+1:0]    idx_wide;
	logic                imp;
	logic                add_eff;
	logic                sub_eff;
	logic                do_add;
	logic                do_sub;
	logic                do_shrink;
	logic                add_n;
	logic                sub_n;
	action_t             act;
	gain_t               step_cur;
	gain_t               grown;
	gain_t               shrunk;
	gain_t               cfg_step;
	logic                adv;
	logic                take;
	logic                fire;

	assign adv         = !v_s2 || result.ready;
	assign trial.ready = !v_s1 || adv;
	assign take        = trial.valid && trial.ready;
	assign fire        = v_s1 && adv;

	assign imp      = err_s1 < best_q;
	assign nxt      = (cur_q == IDX_W'(NUM_GAINS - 1)) ? '0 : cur_q + IDX_W'(1);
	assign idx      = imp ? nxt : cur_q;
	assign step_cur = step_q[cur_q];
	assign grown    = mul_q16(step_cur, K_GROW);
	assign shrunk   = mul_q16(step_cur, K_SHRINK);
	assign cfg_step = mul_q16(cfg_data, K_TENTH);
	assign idx_wide = (IDX_W + 2)'(idx);

	assign add_eff   = !imp && step_add_q;
	assign sub_eff   = !imp && step_sub_q;
	assign do_add    = !add_eff && !sub_eff;
	assign do_sub    = add_eff && !sub_eff;
	assign do_shrink = !do_add && !do_sub;

	always_comb begin
		priority if (do_add) begin
			act   = ACT_ADD;
			add_n = 1'b1;
			sub_n = 1'b0;
			cur_n = idx;
		end else if (do_sub) begin
			act   = ACT_SUB;
			add_n = 1'b1;
			sub_n = 1'b1;
			cur_n = idx;
		end else begin
			act   = ACT_SHRINK;
			add_n = 1'b0;
			sub_n = 1'b0;
			cur_n = nxt;
		end
	end

	// one lane per gain
	always_comb begin
		gain_t              s_k;
		logic signed [34:0] se;
		logic signed [34:0] dbl;
		logic signed [34:0] delta;
		for (int k = 0; k < int'(NUM_GAINS); k++) begin
			s_k   = (imp && cur_q == IDX_W'(k)) ? grown : step_q[k];
			se    = 35'(s_k);
			dbl   = se <<< 1;
			delta = do_sub ? -dbl : se;
			if (idx == IDX_W'(k) && !do_shrink) begin
				gain_n[k] = sat35(35'(gain_q[k]) + delta);
			end else begin
				gain_n[k] = gain_q[k];
			end
			if (imp && cur_q == IDX_W'(k)) begin
				step_n[k] = grown;
			end else if (do_shrink && idx == IDX_W'(k)) begin
				step_n[k] = shrunk;
			end else begin
				step_n[k] = step_q[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < int'(NUM_GAIN_REGS); k++) begin
			gout[k] = (k < int'(NUM_GAINS)) ? gain_n[k] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			best_q     <= BEST_RST;
			cur_q      <= '0;
			step_add_q <= 1'b0;
			step_sub_q <= 1'b0;
			for (int k = 0; k < int'(NUM_GAINS); k++) begin
				gain_q[k] <= '0;
				step_q[k] <= '0;
			end
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (fire) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
			if (cfg_we) begin
				for (int k = 0; k < int'(NUM_GAINS); k++) begin
					if (k < int'(NUM_GAIN_REGS) &&
					    cfg_index == CFG_IDX_W'(int'(REG_GAIN_0) + k)) begin
						gain_q[k] <= cfg_data;
						step_q[k] <= cfg_step;
					end
				end
				if (cfg_index == REG_BEST) begin
					best_q <= cfg_data;
				end
			end else if (fire) begin
				gain_q     <= gain_n;
				step_q     <= step_n;
				cur_q      <= cur_n;
				step_add_q <= add_n;
				step_sub_q <= sub_n;
				if (imp) begin
					best_q <= err_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			err_s1 <= trial.trial_error;
		end
		if (fire) begin
			gout_s2 <= gout;
			tidx_s2 <= idx_wide[IDX_OUT_W-1:0];
			imp_s2  <= imp;
			act_s2  <= act;
		end
	end

	assign result.valid       = v_s2;
	assign result.gain_0      = gout_s2[0];
	assign result.gain_1      = gout_s2[1];
	assign result.gain_2      = gout_s2[2];
	assign result.tuned_index = tidx_s2;
	assign result.improved    = imp_s2;
	assign result.action      = act_s2;

	`TCT_ASSERT_NOW(a_imp_adds, result.valid && result.improved, result.action == ACT_ADD, "improvement without add")
	`TCT_ASSERT_NOW(a_flag_order, step_sub_q, step_add_q, "subtract flag without add flag")
	`TCT_ASSERT_NEXT(a_best_falls, fire && !cfg_we, best_q <= $past(best_q), "best error rose")
	`TCT_ASSERT_NEXT(a_s1_hold, v_s1 && !adv, v_s1 && $stable(err_s1), "stalled word lost")

endmodule

`default_nettype wire
